// File: rtl/core/frbd_pkg.sv
// Shared types, widths and the fractional ratio table of the baud divisor search.
package frbd_pkg;

   localparam int BAUD_W = 22;
   localparam int PCLK_W = 28;
   localparam int Q_W = BAUD_W + 4;
   localparam int DL_W = 16;
   localparam int FRAC_W = 4;
   localparam int NUM_W = 38;
   localparam int DEN_W = 42;
   localparam int RATIO_W = 11;
   localparam int STORED_ENTRIES = 72;
   localparam int IDX_W = 7;

   localparam logic [PCLK_W-1:0] PCLK_RESET = 28'd25000000;
   localparam logic [9:0] SCALE = 10'd1000;
   localparam int EST_START = 1500;
   localparam int EST_STEP = 100;
   localparam int RATIO_LOW = 1100;
   localparam int RATIO_HIGH = 1900;

   localparam logic [1:0] RES_ERR = 2'd0;
   localparam logic [1:0] RES_EXACT = 2'd1;
   localparam logic [1:0] RES_FRAC = 2'd2;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_sel_scaled;
      logic       prod_est;
      logic       prod_dl;
      logic       dl_take;
      logic       est_up;
      logic       est_down;
      logic       est_take_r;
      logic       scan_clear;
      logic       scan_next;
      logic       pick_take;
      logic       res_load;
      logic [1:0] res_kind;
   } frbd_cmd_type;

   typedef struct packed {
      logic baud_zero;
      logic div_done;
      logic quot_zero;
      logic quot_big;
      logic rem_zero;
      logic r_low;
      logic r_high;
      logic est_small;
      logic scan_hit;
      logic scan_last;
      logic out_busy;
   } frbd_stat_type;

   localparam logic [RATIO_W-1:0] FRAC_RATIO [STORED_ENTRIES] = '{
      1000, 1067, 1071, 1077, 1083, 1091, 1100, 1111, 1125, 1133, 1143, 1154,
      1167, 1182, 1200, 1214, 1222, 1231, 1250, 1267, 1273, 1286, 1300, 1308,
      1333, 1357, 1364, 1375, 1385, 1400, 1417, 1429, 1444, 1455, 1462, 1467,
      1500, 1533, 1538, 1545, 1556, 1571, 1583, 1600, 1615, 1625, 1636, 1643,
      1667, 1692, 1700, 1714, 1727, 1733, 1750, 1769, 1778, 1786, 1800, 1818,
      1833, 1846, 1857, 1867, 1875, 1889, 1900, 1909, 1917, 1923, 1929, 1933
   };

   localparam logic [FRAC_W-1:0] FRAC_ADD [STORED_ENTRIES] = '{
      0, 1, 1, 1, 1, 1, 1, 1, 1, 2, 1, 2,
      1, 2, 1, 3, 2, 3, 1, 4, 3, 2, 3, 4,
      1, 5, 4, 3, 5, 2, 5, 3, 4, 5, 6, 7,
      1, 8, 7, 6, 5, 4, 7, 3, 8, 5, 7, 9,
      2, 9, 7, 5, 8, 11, 3, 10, 7, 11, 4, 9,
      5, 11, 6, 13, 7, 8, 9, 10, 11, 12, 13, 14
   };

   localparam logic [FRAC_W-1:0] FRAC_MUL [STORED_ENTRIES] = '{
      1, 15, 14, 13, 12, 11, 10, 9, 8, 15, 7, 13,
      6, 11, 5, 14, 9, 13, 4, 15, 11, 7, 10, 13,
      3, 14, 11, 8, 13, 5, 12, 7, 9, 11, 13, 15,
      2, 15, 13, 11, 9, 7, 12, 5, 13, 8, 11, 14,
      3, 13, 10, 7, 11, 15, 4, 13, 9, 14, 5, 11,
      6, 13, 7, 15, 8, 9, 10, 11, 12, 13, 14, 15
   };

   function automatic logic [RATIO_W-1:0] frac_ratio(input logic [IDX_W-1:0] idx);
      logic [RATIO_W-1:0] val;
      val = '0;
      if (int'(idx) < STORED_ENTRIES) begin
         val = FRAC_RATIO[idx];
      end
      return val;
   endfunction

   function automatic logic [FRAC_W-1:0] frac_add(input logic [IDX_W-1:0] idx);
      logic [FRAC_W-1:0] val;
      val = '0;
      if (int'(idx) < STORED_ENTRIES) begin
         val = FRAC_ADD[idx];
      end
      return val;
   endfunction

   function automatic logic [FRAC_W-1:0] frac_mul(input logic [IDX_W-1:0] idx);
      logic [FRAC_W-1:0] val;
      val = '0;
      if (int'(idx) < STORED_ENTRIES) begin
         val = FRAC_MUL[idx];
      end
      return val;
   endfunction

endpackage

// File: rtl/core/frbd_div.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
module frbd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [frbd_pkg::NUM_W-1:0]  dividend,
   input  logic [frbd_pkg::DEN_W-1:0]  divisor,
   output logic                        done,
   output logic [frbd_pkg::NUM_W-1:0]  quot,
   output logic [frbd_pkg::DEN_W-1:0]  rem
);
   import frbd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] num_in;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff = trial - {1'b0, den_ff};
   assign fits = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(NUM_W);
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem = rem_ff;

endmodule

// File: rtl/core/frbd_dp.sv
// Datapath: clock register, operand products, estimate, table scan and result register.
module frbd_dp #(
   parameter int EST_W = 13,
   parameter int SCAN_LIMIT = 72
) (
   input  logic                          clock,
   input  logic                          reset,
   input  frbd_pkg::frbd_cmd_type        cmd,
   output frbd_pkg::frbd_stat_type       stat,
   input  logic [frbd_pkg::BAUD_W-1:0]   req_baud,
   input  logic                          csr_write,
   input  logic [frbd_pkg::PCLK_W-1:0]   csr_value,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [frbd_pkg::DL_W-1:0]     rsp_dl,
   output logic [frbd_pkg::FRAC_W-1:0]   rsp_mul,
   output logic [frbd_pkg::FRAC_W-1:0]   rsp_add,
   output logic                          rsp_status
);
   import frbd_pkg::*;

   localparam int PE_W = Q_W + EST_W;
   localparam int PD_W = Q_W + DL_W;

   logic [PCLK_W-1:0]      pclk_ff;
   logic [PCLK_W-1:0]      pclk_in;
   logic [BAUD_W-1:0]      baud_ff;
   logic [Q_W-1:0]         q_ff;
   logic [NUM_W-1:0]       scaled_ff;
   logic [DEN_W-1:0]       prod_ff;
   logic [DEN_W-1:0]       prod_in;
   logic [EST_W-1:0]       est_ff;
   logic [EST_W-1:0]       est_in;
   logic [DL_W-1:0]        dl_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [FRAC_W-1:0]      pick_mul_ff;
   logic [FRAC_W-1:0]      pick_add_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [DL_W-1:0]        rsp_dl_ff;
   logic [FRAC_W-1:0]      rsp_mul_ff;
   logic [FRAC_W-1:0]      rsp_add_ff;
   logic                   rsp_status_ff;

   logic [Q_W-1:0]         q_new;
   logic [NUM_W-1:0]       scaled_w;
   logic [PE_W-1:0]        prod_est_w;
   logic [PD_W-1:0]        prod_dl_w;
   logic [NUM_W-1:0]       dividend;
   logic                   div_done;
   logic [NUM_W-1:0]       quot;
   logic [DEN_W-1:0]       rem;
   logic [RATIO_W-1:0]     ratio_cur;
   logic [RATIO_W-1:0]     ratio_prev;
   logic [RATIO_W-1:0]     gap_up;
   logic [RATIO_W-1:0]     gap_down;
   logic                   take_prev;
   logic [IDX_W-1:0]       pick_idx;

   frbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (prod_ff),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   assign q_new = {req_baud, 4'b0000};
   assign scaled_w = NUM_W'(pclk_ff) * NUM_W'(SCALE);
   assign prod_est_w = PE_W'(q_ff) * PE_W'(est_ff);
   assign prod_dl_w = PD_W'(q_ff) * PD_W'(dl_ff);
   assign dividend = cmd.div_sel_scaled ? scaled_ff : NUM_W'(pclk_ff);

   // Nearest-entry choice: the estimate sits above the previous entry once the
   // scan has reached the first entry that is not below it.
   assign ratio_cur = frac_ratio(idx_ff);
   assign ratio_prev = frac_ratio(idx_ff - IDX_W'(1));
   assign gap_up = ratio_cur - est_ff[RATIO_W-1:0];
   assign gap_down = est_ff[RATIO_W-1:0] - ratio_prev;
   assign take_prev = (idx_ff != '0) && (gap_up > gap_down);
   assign pick_idx = take_prev ? (idx_ff - IDX_W'(1)) : idx_ff;

   always_comb begin
      pclk_in = pclk_ff;
      if (csr_write) begin
         pclk_in = csr_value;
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (cmd.load) begin
         prod_in = DEN_W'(q_new);
      end else if (cmd.prod_est) begin
         prod_in = DEN_W'(prod_est_w);
      end else if (cmd.prod_dl) begin
         prod_in = DEN_W'(prod_dl_w);
      end
   end

   always_comb begin
      est_in = est_ff;
      if (cmd.load) begin
         est_in = EST_W'(EST_START);
      end else if (cmd.est_up) begin
         est_in = est_ff + EST_W'(EST_STEP);
      end else if (cmd.est_down) begin
         est_in = est_ff - EST_W'(EST_STEP);
      end else if (cmd.est_take_r) begin
         est_in = quot[EST_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pclk_ff <= PCLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pclk_ff <= pclk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      est_ff <= est_in;
      if (cmd.load) begin
         baud_ff <= req_baud;
         q_ff <= q_new;
         scaled_ff <= scaled_w;
      end
      if (cmd.dl_take) begin
         dl_ff <= quot[DL_W-1:0];
      end
      if (cmd.scan_clear) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.pick_take) begin
         pick_mul_ff <= frac_mul(pick_idx);
         pick_add_ff <= frac_add(pick_idx);
      end
      if (cmd.res_load) begin
         unique case (cmd.res_kind)
            RES_EXACT: begin
               rsp_dl_ff <= dl_ff;
               rsp_mul_ff <= FRAC_W'(1);
               rsp_add_ff <= '0;
               rsp_status_ff <= 1'b0;
            end
            RES_FRAC: begin
               rsp_dl_ff <= dl_ff;
               rsp_mul_ff <= pick_mul_ff;
               rsp_add_ff <= pick_add_ff;
               rsp_status_ff <= 1'b0;
            end
            default: begin
               rsp_dl_ff <= '0;
               rsp_mul_ff <= '0;
               rsp_add_ff <= '0;
               rsp_status_ff <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      stat.baud_zero = (baud_ff == '0);
      stat.div_done = div_done;
      stat.quot_zero = (quot == '0);
      stat.quot_big = (quot[NUM_W-1:DL_W] != '0);
      stat.rem_zero = (rem == '0);
      stat.r_low = (quot <= NUM_W'(RATIO_LOW));
      stat.r_high = (quot >= NUM_W'(RATIO_HIGH));
      stat.est_small = (est_ff <= EST_W'(EST_STEP));
      stat.scan_hit = (est_ff <= EST_W'(ratio_cur));
      stat.scan_last = (idx_ff == IDX_W'(SCAN_LIMIT - 1));
      stat.out_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dl = rsp_dl_ff;
   assign rsp_mul = rsp_mul_ff;
   assign rsp_add = rsp_add_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: rtl/core/frbd_ctrl.sv
// Controller state machine that sequences the exact check, the search tries and the table scan.
module frbd_ctrl #(
   parameter int MAX_TRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  frbd_pkg::frbd_stat_type  stat,
   output frbd_pkg::frbd_cmd_type   cmd
);
   import frbd_pkg::*;

   localparam int TRY_W = $clog2(MAX_TRIES);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CHECK   = 4'd1;
   localparam logic [3:0] ST_EXACT   = 4'd2;
   localparam logic [3:0] ST_PROD_E  = 4'd3;
   localparam logic [3:0] ST_START1  = 4'd4;
   localparam logic [3:0] ST_WAIT1   = 4'd5;
   localparam logic [3:0] ST_PROD_D  = 4'd6;
   localparam logic [3:0] ST_START2  = 4'd7;
   localparam logic [3:0] ST_WAIT2   = 4'd8;
   localparam logic [3:0] ST_SCAN    = 4'd9;
   localparam logic [3:0] ST_FINISH  = 4'd10;

   logic [3:0]       state_ff;
   logic [3:0]       state_in;
   logic [TRY_W-1:0] try_ff;
   logic [TRY_W-1:0] try_in;
   logic [1:0]       kind_ff;
   logic [1:0]       kind_in;
   logic             last_try;

   assign last_try = (try_ff == TRY_W'(MAX_TRIES - 1));

   always_comb begin
      state_in = state_ff;
      try_in = try_ff;
      kind_in = kind_ff;
      cmd = '0;
      cmd.res_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               try_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.baud_zero) begin
               kind_in = RES_ERR;
               state_in = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_EXACT;
            end
         end
         ST_EXACT: begin
            if (stat.div_done) begin
               if (!stat.rem_zero) begin
                  state_in = ST_PROD_E;
               end else if (stat.quot_zero || stat.quot_big) begin
                  kind_in = RES_ERR;
                  state_in = ST_FINISH;
               end else begin
                  cmd.dl_take = 1'b1;
                  kind_in = RES_EXACT;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PROD_E: begin
            cmd.prod_est = 1'b1;
            state_in = ST_START1;
         end
         ST_START1: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_scaled = 1'b1;
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (stat.div_done) begin
               if (stat.quot_zero || stat.quot_big) begin
                  kind_in = RES_ERR;
                  state_in = ST_FINISH;
               end else begin
                  cmd.dl_take = 1'b1;
                  state_in = ST_PROD_D;
               end
            end
         end
         ST_PROD_D: begin
            cmd.prod_dl = 1'b1;
            state_in = ST_START2;
         end
         ST_START2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_scaled = 1'b1;
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (stat.div_done) begin
               if (!stat.r_low && !stat.r_high) begin
                  cmd.est_take_r = 1'b1;
                  cmd.scan_clear = 1'b1;
                  state_in = ST_SCAN;
               end else if (stat.r_high && stat.est_small) begin
                  kind_in = RES_ERR;
                  state_in = ST_FINISH;
               end else if (last_try) begin
                  kind_in = RES_ERR;
                  state_in = ST_FINISH;
               end else begin
                  cmd.est_up = stat.r_low;
                  cmd.est_down = stat.r_high;
                  try_in = try_ff + TRY_W'(1);
                  state_in = ST_PROD_E;
               end
            end
         end
         ST_SCAN: begin
            if (stat.scan_hit) begin
               cmd.pick_take = 1'b1;
               kind_in = RES_FRAC;
               state_in = ST_FINISH;
            end else if (stat.scan_last) begin
               kind_in = RES_ERR;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         try_ff <= '0;
         kind_ff <= RES_ERR;
      end else begin
         state_ff <= state_in;
         try_ff <= try_in;
         kind_ff <= kind_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: rtl/core/fractional_baud_divisor_search_unit.sv
// Top level of the fractional baud divisor search unit.
//
// For each requested baud rate this unit returns the 16-bit divisor latch value and the
// fractional divider pair (multiplier, add value) for a 16x oversampling UART running from
// the peripheral clock held in the csr register (reset value 25 MHz). When the clock is an
// exact multiple of 16 times the baud rate the pair is (1, 0); otherwise an estimate of the
// fractional ratio, in thousandths, is stepped by 0.1 from 1.5 until the achieved ratio
// lands strictly between 1.1 and 1.9, and is then snapped to the nearest entry of the
// ratio table. A zero baud rate, a divisor of zero or above 65535, a run of MAX_TRIES tries
// without success, a ratio still too high with the estimate at 0.1 or below, or no table
// match returns status 1 with all other fields zero. One request is worked at a time. All
// quotients come from a single shared bit-serial divider: an exact-rate request needs one
// division, and a searched request needs two more for each try (1 to MAX_TRIES tries) and
// then scans the table entries, one per cycle (up to 72). A response still waiting in the
// output register holds back the next result until it is taken.
// The result sits in an output register, so the unit takes the next request while the
// previous response still waits. The clock register may be written only while idle.
module fractional_baud_divisor_search_unit #(
   parameter int TABLE_ENTRIES = 72,
   parameter int MAX_TRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [21:0] baud_rate, [23:22] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // Response: [15:0] divisor_latch, [19:16] mul_val, [23:20] add_val.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // Response user bits: [0] status.
   output logic [0:0]  rsp_tuser,
   // Peripheral clock frequency in hertz.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [frbd_pkg::PCLK_W-1:0] csr_data
);
   import frbd_pkg::*;

   // A bound on the largest estimate that a run of increases can reach sets the estimate width.
   localparam int EST_MAX = EST_START + EST_STEP * MAX_TRIES;
   localparam int EST_W = $clog2(EST_MAX + 1);
   localparam int SCAN_LIMIT = (TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES
                                                                : STORED_ENTRIES;

   frbd_cmd_type      cmd;
   frbd_stat_type     stat;
   logic              rsp_valid;
   logic [DL_W-1:0]   rsp_dl;
   logic [FRAC_W-1:0] rsp_mul;
   logic [FRAC_W-1:0] rsp_add;
   logic              rsp_status;

   // The clock register is always writable; writes are expected only while idle.
   assign csr_ready = 1'b1;

   frbd_ctrl #(
      .MAX_TRIES (MAX_TRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   frbd_dp #(
      .EST_W      (EST_W),
      .SCAN_LIMIT (SCAN_LIMIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_baud   (req_tdata[BAUD_W-1:0]),
      .csr_write  (csr_valid),
      .csr_value  (csr_data),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_valid),
      .rsp_dl     (rsp_dl),
      .rsp_mul    (rsp_mul),
      .rsp_add    (rsp_add),
      .rsp_status (rsp_status)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata = {rsp_add, rsp_mul, rsp_dl};
   assign rsp_tuser = rsp_status;

endmodule

// File: rtl/core/frbd_checker.sv
// Port-level checker for the fractional baud divisor search unit, with its bind.
module frbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // An error response carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("error response with nonzero fields");

   // A good response has a nonzero divisor and an add value below the multiplier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[15:0] != 16'd0 && rsp_tdata[23:20] < rsp_tdata[19:16])
      else $error("good response with an impossible divider setting");

   // Requests are worked one at a time: the unit is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in progress");

endmodule

bind fractional_baud_divisor_search_unit frbd_checker u_frbd_checker (.*);

// File: tb/sv/fractional_baud_divisor_search_unit_tb.sv
// Self-checking testbench for the fractional baud divisor search unit.
`timescale 1ns / 100ps

module fractional_baud_divisor_search_unit_tb;

   import frbd_pkg::*;

   // The block is built with its stock table size and try budget.
   localparam int TABLE_ENTRIES = 72;
   localparam int MAX_TRIES = 16;

   // The response side is held off this long once, so that the block fills up and the
   // request side stalls behind it.
   localparam int HOLD_CYCLES = 3000;
   // This bound is several times the longest stretch in which no handshake of any kind can
   // take place.
   localparam int WATCHDOG_LIMIT = 20000;
   // Quiet cycles after the last response, enough to expose a stray extra response.
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_REQUESTS = 102;
   localparam int RANDOM_PHASES = 3;

   // Clock settings visited after the reset value, extremes first.
   localparam logic [PCLK_W-1:0] PHASE_CLOCK [10] = '{
      28'd0, 28'd1, 28'hFFFFFFF, 28'd200000000, 28'd18432000,
      28'd14745600, 28'd100000000, 28'd60000000, 28'd12000000, 28'd25000000
   };

   // Ratio table of the fractional divider, in thousandths, with the matching pairs.
   localparam int unsigned RATIO_THOUSANDTHS [72] = '{
      1000, 1067, 1071, 1077, 1083, 1091, 1100, 1111, 1125, 1133, 1143, 1154,
      1167, 1182, 1200, 1214, 1222, 1231, 1250, 1267, 1273, 1286, 1300, 1308,
      1333, 1357, 1364, 1375, 1385, 1400, 1417, 1429, 1444, 1455, 1462, 1467,
      1500, 1533, 1538, 1545, 1556, 1571, 1583, 1600, 1615, 1625, 1636, 1643,
      1667, 1692, 1700, 1714, 1727, 1733, 1750, 1769, 1778, 1786, 1800, 1818,
      1833, 1846, 1857, 1867, 1875, 1889, 1900, 1909, 1917, 1923, 1929, 1933
   };
   localparam int unsigned PAIR_ADD [72] = '{
      0, 1, 1, 1, 1, 1, 1, 1, 1, 2, 1, 2,
      1, 2, 1, 3, 2, 3, 1, 4, 3, 2, 3, 4,
      1, 5, 4, 3, 5, 2, 5, 3, 4, 5, 6, 7,
      1, 8, 7, 6, 5, 4, 7, 3, 8, 5, 7, 9,
      2, 9, 7, 5, 8, 11, 3, 10, 7, 11, 4, 9,
      5, 11, 6, 13, 7, 8, 9, 10, 11, 12, 13, 14
   };
   localparam int unsigned PAIR_MUL [72] = '{
      1, 15, 14, 13, 12, 11, 10, 9, 8, 15, 7, 13,
      6, 11, 5, 14, 9, 13, 4, 15, 11, 7, 10, 13,
      3, 14, 11, 8, 13, 5, 12, 7, 9, 11, 13, 15,
      2, 15, 13, 11, 9, 7, 12, 5, 13, 8, 11, 14,
      3, 13, 10, 7, 11, 15, 4, 13, 9, 14, 5, 11,
      6, 13, 7, 15, 8, 9, 10, 11, 12, 13, 14, 15
   };

   // One divider setting as the block reports it.
   typedef struct packed {
      logic [DL_W-1:0]   divisor_latch;
      logic [FRAC_W-1:0] mul_val;
      logic [FRAC_W-1:0] add_val;
      logic              status;
   } divider_setting_type;

   // The scoreboard keeps its own copy of the clock register and a queue of the
   // divider settings that are still owed by the block, oldest first.
   class baud_divisor_scoreboard;
      logic [PCLK_W-1:0]   pclk;
      divider_setting_type owed_settings[$];
      int                  errors;

      function new();
         pclk = PCLK_RESET;
         errors = 0;
      endfunction

      function void set_clock(logic [PCLK_W-1:0] value);
         pclk = value;
      endfunction

      function int pending();
         return owed_settings.size();
      endfunction

      // Works out the divider setting for one baud rate under the current clock.
      function divider_setting_type predict_setting(logic [BAUD_W-1:0] baud);
         longint unsigned clk;
         longint unsigned q;
         longint unsigned scaled;
         longint unsigned dl;
         longint unsigned est;
         longint unsigned r;
         int pick;
         bit found;
         divider_setting_type res;
         res = '{divisor_latch: '0, mul_val: '0, add_val: '0, status: 1'b1};
         if (baud == 0) begin
            return res;
         end
         clk = pclk;
         q = 16 * longint'(baud);
         // An exact divisor needs no fraction; a zero clock lands here too.
         if (clk % q == 0) begin
            dl = clk / q;
            if (dl == 0 || dl > 65535) begin
               return res;
            end
            res = '{divisor_latch: dl[15:0], mul_val: 4'd1, add_val: 4'd0, status: 1'b0};
            return res;
         end
         scaled = clk * 1000;
         est = EST_START;
         found = 1'b0;
         for (int tries = 0; tries < MAX_TRIES && !found; tries++) begin
            dl = scaled / (q * est);
            if (dl == 0 || dl > 65535) begin
               return res;
            end
            r = scaled / (q * dl);
            if (r <= RATIO_LOW) begin
               est += EST_STEP;
            end else if (r >= RATIO_HIGH) begin
               if (est <= EST_STEP) begin
                  return res;
               end
               est -= EST_STEP;
            end else begin
               est = r;
               found = 1'b1;
            end
         end
         if (!found) begin
            return res;
         end
         // Snap the estimate to the nearer of the two table entries around it; a tie
         // goes to the upper entry.
         for (int i = 0; i < TABLE_ENTRIES && i < 72; i++) begin
            if (est <= RATIO_THOUSANDTHS[i]) begin
               pick = i;
               if (i != 0 && (RATIO_THOUSANDTHS[i] - est) > (est - RATIO_THOUSANDTHS[i-1])) begin
                  pick = i - 1;
               end
               res.divisor_latch = dl[15:0];
               res.mul_val = FRAC_W'(PAIR_MUL[pick]);
               res.add_val = FRAC_W'(PAIR_ADD[pick]);
               res.status = 1'b0;
               return res;
            end
         end
         return res;
      endfunction

      function void note_request(logic [BAUD_W-1:0] baud);
         owed_settings.push_back(predict_setting(baud));
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(divider_setting_type got);
         divider_setting_type want;
         if (owed_settings.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", got));
            return;
         end
         want = owed_settings.pop_front();
         if (got.divisor_latch !== want.divisor_latch) begin
            report_mismatch($sformatf("divisor_latch %0d, predicted %0d",
                                      got.divisor_latch, want.divisor_latch));
         end
         if (got.mul_val !== want.mul_val) begin
            report_mismatch($sformatf("mul_val %0d, predicted %0d", got.mul_val, want.mul_val));
         end
         if (got.add_val !== want.add_val) begin
            report_mismatch($sformatf("add_val %0d, predicted %0d", got.add_val, want.add_val));
         end
         if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [23:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              csr_valid;
   logic              csr_ready;
   logic [PCLK_W-1:0] csr_data;

   baud_divisor_scoreboard sb = new();

   // When calm is set neither side idles; hold_rsp asks the response side for one long
   // hold-off and is cleared by that side once the hold-off is over.
   bit calm;
   bit hold_rsp;
   int idle_cycles;

   fractional_baud_divisor_search_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_TRIES(MAX_TRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap lengths: mostly none, often a few cycles, now and then a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // Baud rates are spread over all magnitudes by first choosing a bit length. A share is
   // aimed at exact divisors of the clock, and a few hit the two ends of the field.
   function automatic logic [BAUD_W-1:0] pick_baud(logic [PCLK_W-1:0] clk);
      int roll;
      int width;
      int unsigned dl;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         return '0;
      end
      if (roll < 6) begin
         return '1;
      end
      if (roll < 20) begin
         dl = $urandom_range(1, 2000);
         return BAUD_W'(clk / (16 * dl));
      end
      width = $urandom_range(1, BAUD_W);
      return BAUD_W'($urandom_range((1 << width) - 1, 1 << (width - 1)));
   endfunction

   // Offers one request; returns after the accepting edge and a random gap. The ready is
   // sampled at the falling edge, where everything driven at the rising edge has settled.
   task automatic send_request(input logic [BAUD_W-1:0] baud);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, baud};
      @(negedge clock);
      while (!req_tready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      sb.note_request(baud);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes the clock register; called only while no request is in flight.
   task automatic write_pclk(input logic [PCLK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_clock(value);
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Response side: bursts of ready broken by random stalls, plus one long hold-off on
   // request. Every change is made at a rising edge, never twice in one step.
   initial begin : response_sink
      int stall;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Responses are checked at the falling edge before the rising edge that accepts them.
   // The same block runs the watchdog on cycles without any handshake.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response('{divisor_latch: rsp_tdata[15:0], mul_val: rsp_tdata[19:16],
                                add_val: rsp_tdata[23:20], status: rsp_tuser[0]});
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("fractional_baud_divisor_search_unit: mismatch");
               $finish;
            end
         end
      end
   end

   // Directed rates under the reset clock of 25 MHz: both ends of the field, common line
   // rates, exact divisors, and rates whose divisor is zero or too wide.
   localparam logic [BAUD_W-1:0] DIRECTED_BAUD [22] = '{
      22'd0, 22'h3FFFFF, 22'd1, 22'd9600, 22'd115200, 22'd19200, 22'd15625, 22'd1562500,
      22'd2400, 22'd300, 22'd57600, 22'd921600, 22'd3000000, 22'd4000000, 22'd110,
      22'd1200, 22'd38400, 22'd230400, 22'd460800, 22'd1000000, 22'd31250, 22'd2097152
   };

   initial begin : stimulus
      logic [PCLK_W-1:0] clk;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      idle_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BAUD[i]) begin
         send_request(DIRECTED_BAUD[i]);
      end

      // Random phases, each under its own clock setting. The register is rewritten only
      // after every owed response has come back. Three phases run with no idling, and the
      // phase at 200 MHz carries the long response hold-off.
      for (int phase = 0; phase < 10 + RANDOM_PHASES; phase++) begin
         wait_for_idle();
         clk = (phase < 10) ? PHASE_CLOCK[phase] : PCLK_W'($urandom_range(1, 200000000));
         write_pclk(clk);
         calm = (phase % 4 == 3);
         if (phase == 3) begin
            hold_rsp = 1'b1;
         end
         repeat (PHASE_REQUESTS) begin
            send_request(pick_baud(clk));
         end
      end

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("fractional_baud_divisor_search_unit: match");
      end else begin
         $display("fractional_baud_divisor_search_unit: mismatch");
      end
      $finish;
   end

endmodule
